[rtl/core/pvf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvf_pkg
// types and constants shared by the proximity vector fusion block
// ----------------------------------------------------------------------------
package pvf_pkg;

    typedef struct packed {
        logic        command;
        logic [15:0] distance;
        logic signed [15:0] angle;
        logic        blob_is_red;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        magnitude;
        logic signed [15:0] direction;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed {
        logic        active;
        logic [15:0] denom;
        logic [23:0] offset;
        logic [15:0] gain;
        logic [15:0] angle;
        logic        last;
    } job_t;

    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PROX_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROX_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROX_OFS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROX_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NB_REACH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_GAP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NB_OFS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NB_GAIN    = 3'd7;

    localparam logic [16:0] INV_GAIN  = 17'd39797;
    localparam logic [15:0] GAP_FLOOR = 16'd4;
    localparam logic [15:0] W_MAX     = 16'd32768;

    function automatic logic [31:0] atan_of(input logic [4:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[rtl/core/pvf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvf_front
// configuration registers, frame item count and item classification
// ----------------------------------------------------------------------------
module pvf_front #(
    parameter int MAX_ITEMS_PER_FRAME = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pvf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pvf_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pvf_pkg::in_item_t                 in_data,
    output logic                                   job_valid,
    input  wire logic                              job_full,
    output pvf_pkg::job_t                          job
);
    localparam int CNT_W = $clog2(MAX_ITEMS_PER_FRAME + 1);

    logic [15:0] prox_min_reg, prox_max_reg, prox_gain_reg;
    logic [15:0] nb_reach_reg, robot_gap_reg, nb_gain_reg;
    logic [23:0] prox_ofs_reg, nb_ofs_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic        counted, use_it;
    logic [16:0] gap;
    logic        accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prox_min_reg  <= 16'd205;
            prox_max_reg  <= 16'd1638;
            prox_ofs_reg  <= 24'd10240;
            prox_gain_reg <= 16'd3745;
            nb_reach_reg  <= 16'd2253;
            robot_gap_reg <= 16'd1126;
            nb_ofs_reg    <= 24'd14894;
            nb_gain_reg   <= 16'd66;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pvf_pkg::REG_PROX_MIN:  prox_min_reg  <= cfg_data[15:0];
                pvf_pkg::REG_PROX_MAX:  prox_max_reg  <= cfg_data[15:0];
                pvf_pkg::REG_PROX_OFS:  prox_ofs_reg  <= cfg_data;
                pvf_pkg::REG_PROX_GAIN: prox_gain_reg <= cfg_data[15:0];
                pvf_pkg::REG_NB_REACH:  nb_reach_reg  <= cfg_data[15:0];
                pvf_pkg::REG_ROBOT_GAP: robot_gap_reg <= cfg_data[15:0];
                pvf_pkg::REG_NB_OFS:    nb_ofs_reg    <= cfg_data;
                pvf_pkg::REG_NB_GAIN:   nb_gain_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign in_stall  = job_full;
    assign accept    = in_valid && !job_full;
    assign job_valid = accept;
    assign counted   = count_reg < CNT_W'(MAX_ITEMS_PER_FRAME);
    assign gap       = {1'b0, in_data.distance} - {1'b0, robot_gap_reg};

    always_comb
    begin
        job.angle = in_data.angle;
        job.last  = in_data.last;
        if (!in_data.command)
        begin
            use_it     = in_data.distance >= prox_min_reg
                         && in_data.distance <= prox_max_reg;
            job.denom  = in_data.distance;
            job.offset = prox_ofs_reg;
            job.gain   = prox_gain_reg;
        end
        else
        begin
            use_it     = in_data.blob_is_red && in_data.distance <= nb_reach_reg;
            // gap not positive: floor at one millimeter
            job.denom  = (gap[16] || gap[15:0] == 16'd0) ? pvf_pkg::GAP_FLOOR
                                                         : gap[15:0];
            job.offset = nb_ofs_reg;
            job.gain   = nb_gain_reg;
        end
        job.active = use_it && counted;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (in_data.last)
                count_next = '0;
            else if (counted)
                count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule
`default_nettype wire

[rtl/core/pvf_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvf_queue
// two entry queue between classification and the arithmetic back end
// ----------------------------------------------------------------------------
module pvf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pvf_pkg::job_t push_data,
    output logic               full,
    output logic               not_empty,
    input  wire logic          pop,
    output pvf_pkg::job_t      head
);
    pvf_pkg::job_t mem_reg [2];
    logic          wr_reg, rd_reg;
    logic [1:0]    cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= !wr_reg;
            if (pop)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[rtl/core/pvf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pvf_back
// reciprocal, weight, rotating cordic, accumulation and vectoring output
// ----------------------------------------------------------------------------
module pvf_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_ready,
    input  wire pvf_pkg::job_t      job,
    output logic                    job_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pvf_pkg::out_item_t      out_data
);
    localparam int STEP_W = $clog2(CORDIC_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MUL, S_CLAMP, S_PRE, S_ROT, S_ACC,
        S_VPRE, S_VEC, S_MAG, S_DONE
    } state_t;

    state_t state_reg;
    logic [24:0] rem_reg;
    logic [24:0] quo_reg;
    logic [4:0]  bit_reg;
    logic [STEP_W-1:0] step_reg;
    logic signed [41:0] prod_reg;
    logic [15:0] w_reg;
    logic signed [40:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [31:0] zv_reg;
    logic signed [23:0] sum_x_reg, sum_y_reg;
    logic        last_reg;
    logic [15:0] angle_reg;
    logic [15:0] dist_reg;
    logic [23:0] ofs_reg;
    logic [15:0] gain_reg;
    logic signed [57:0] mag_reg;

    logic [25:0] trial;
    logic signed [40:0] xs, ys;
    logic [31:0] at;
    logic signed [24:0] ax, ay;
    logic signed [24:0] recip;

    assign trial   = {rem_reg, quo_reg[24]} - {10'd0, dist_reg};
    assign xs      = x_reg >>> step_reg;
    assign ys      = y_reg >>> step_reg;
    assign at      = pvf_pkg::atan_of(5'(step_reg));
    assign ax      = 25'(sum_x_reg) + 25'(x_reg >>> 16);
    assign ay      = 25'(sum_y_reg) + 25'(y_reg >>> 16);
    assign recip   = (dist_reg == 16'd0 || quo_reg[24]) ? 25'h0FFFFFF
                                                       : {1'b0, quo_reg[23:0]};
    assign job_pop = state_reg == S_IDLE && job_ready && !out_valid;

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        begin
            if (v > 25'sd8388607)
                return 24'sh7FFFFF;
            else if (v < -25'sd8388608)
                return 24'sh800000;
            return v[23:0];
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_pop)
                    begin
                        dist_reg  <= job.denom;
                        ofs_reg   <= job.offset;
                        gain_reg  <= job.gain;
                        angle_reg <= job.angle;
                        last_reg  <= job.last;
                        // dividend 2^24 shifted in from the top of quo
                        rem_reg   <= '0;
                        quo_reg   <= 25'h1000000;
                        bit_reg   <= 5'd24;
                        state_reg <= job.active ? S_DIV
                                     : (job.last ? S_VPRE : S_IDLE);
                    end
                end
                S_DIV:
                begin
                    // restoring divide, one quotient bit per cycle
                    if (!trial[25])
                        rem_reg <= trial[24:0];
                    else
                        rem_reg <= {rem_reg[23:0], quo_reg[24]};
                    quo_reg <= {quo_reg[23:0], !trial[25]};
                    bit_reg <= bit_reg - 5'd1;
                    if (bit_reg == 5'd0)
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // full 25 bit quotient; top bit set means saturate
                    prod_reg  <= 42'(recip - $signed({1'b0, ofs_reg}))
                                 * $signed({26'd0, gain_reg});
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (prod_reg < 0)
                        w_reg <= 16'd0;
                    else if ((prod_reg >>> 13) > 42'sd32768)
                        w_reg <= pvf_pkg::W_MAX;
                    else
                        w_reg <= 16'(prod_reg >>> 13);
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    if (w_reg == 16'd0)
                        state_reg <= last_reg ? S_VPRE : S_IDLE;
                    else
                    begin
                        y_reg <= '0;
                        if ($signed(angle_reg) > 16'sd16384)
                        begin
                            x_reg <= -(41'(w_reg) * 41'(pvf_pkg::INV_GAIN));
                            z_reg <= (34'($signed(angle_reg)) <<< 16)
                                     - 34'sh80000000;
                        end
                        else if ($signed(angle_reg) < -16'sd16384)
                        begin
                            x_reg <= -(41'(w_reg) * 41'(pvf_pkg::INV_GAIN));
                            z_reg <= (34'($signed(angle_reg)) <<< 16)
                                     + 34'sh80000000;
                        end
                        else
                        begin
                            x_reg <= 41'(w_reg) * 41'(pvf_pkg::INV_GAIN);
                            z_reg <= 34'($signed(angle_reg)) <<< 16;
                        end
                        step_reg  <= '0;
                        state_reg <= S_ROT;
                    end
                end
                S_ROT:
                begin
                    if (!z_reg[33])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - $signed({2'b0, at});
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + $signed({2'b0, at});
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sum_x_reg <= sat24(ax);
                    sum_y_reg <= sat24(ay);
                    state_reg <= last_reg ? S_VPRE : S_IDLE;
                end
                S_VPRE:
                begin
                    if (sum_x_reg < 0)
                    begin
                        x_reg  <= -(41'(sum_x_reg) <<< 8);
                        y_reg  <= -(41'(sum_y_reg) <<< 8);
                        zv_reg <= 32'h80000000;
                    end
                    else
                    begin
                        x_reg  <= 41'(sum_x_reg) <<< 8;
                        y_reg  <= 41'(sum_y_reg) <<< 8;
                        zv_reg <= '0;
                    end
                    step_reg  <= '0;
                    state_reg <= S_VEC;
                end
                S_VEC:
                begin
                    if (y_reg > 0)
                    begin
                        x_reg  <= x_reg + ys;
                        y_reg  <= y_reg - xs;
                        zv_reg <= zv_reg + at;
                    end
                    else
                    begin
                        x_reg  <= x_reg - ys;
                        y_reg  <= y_reg + xs;
                        zv_reg <= zv_reg - at;
                    end
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    mag_reg   <= 58'(x_reg) * $signed({1'b0, pvf_pkg::INV_GAIN});
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (sum_x_reg == 0 && sum_y_reg == 0)
                    begin
                        out_data.magnitude <= '0;
                        out_data.direction <= '0;
                    end
                    else
                    begin
                        if (mag_reg < 0)
                            out_data.magnitude <= '0;
                        else if ((mag_reg >>> 24) > 58'sd32768)
                            out_data.magnitude <= pvf_pkg::W_MAX;
                        else
                            out_data.magnitude <= 16'(mag_reg >>> 24);
                        out_data.direction <= 16'((zv_reg + 32'h8000) >> 16);
                    end
                    out_valid <= 1'b1;
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/proximity_vector_fusion.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_vector_fusion
// fuses a frame of polar proximity and blob readings into one vector
// ----------------------------------------------------------------------------
// usage:
//  in channel (in_valid/in_stall/in_data) takes one reading per transaction;
//  in_data.last closes the frame and yields one out transaction
//  (out_valid/out_stall/out_data) with magnitude and direction.
//  registers are written through cfg_we/cfg_index/cfg_data while idle.
//  an in-range item passes through these back end steps in order:
//  taking it from the queue, the reciprocal divider, multiply, clamp,
//  prerotation, CORDIC_STEPS rotations and accumulate; one whose weight
//  clamps to zero leaves at the prerotation step, and an item outside
//  the band or past the frame limit leaves once taken from the queue.
//  a last item adds vectoring: prerotation, CORDIC_STEPS rotations,
//  magnitude scaling and output. a two entry queue lets the front take items while the back end works.
//  reset restores register defaults and clears sums and item count.
//  while out_stall is high the result holds and the back end waits.
// ----------------------------------------------------------------------------
module proximity_vector_fusion #(
    parameter int MAX_ITEMS_PER_FRAME = 64,
    parameter int CORDIC_STEPS        = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pvf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pvf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire pvf_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output pvf_pkg::out_item_t                 out_data
);
    logic          push, full, not_empty, pop;
    pvf_pkg::job_t push_job, head_job;

    pvf_front #(.MAX_ITEMS_PER_FRAME(MAX_ITEMS_PER_FRAME)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .in_valid, .in_stall, .in_data,
        .job_valid(push), .job_full(full), .job(push_job)
    );

    pvf_queue u_queue (
        .clk, .rst_n, .push, .push_data(push_job), .full, .not_empty,
        .pop, .head(head_job)
    );

    pvf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk, .rst_n, .job_ready(not_empty), .job(head_job), .job_pop(pop),
        .out_valid, .out_stall, .out_data
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into full queue");
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.magnitude <= 16'd32768)
        else $error("magnitude above one");
endmodule
`default_nettype wire

[tb/proximity_vector_fusion_test.sv]
// ----------------------------------------------------------------------------
// proximity_vector_fusion_test
// Self-checking bench for the vector fusion block. A predictor is built into
// the bench and tracks the register settings and the x/y sums. It produces
// the vector expected at the end of each frame, and every output
// transaction is compared with it. The input idles and the output stalls at
// random, and the bench writes several register settings between phases.
// ----------------------------------------------------------------------------
module proximity_vector_fusion_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  STEPS       = 16;
    localparam int  FRAME_LIMIT = 64;
    localparam int  SETTLE      = 120;
    localparam longint CYCLE_LIMIT = 1500000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [pvf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pvf_pkg::CFG_W-1:0]     cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    pvf_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    pvf_pkg::out_item_t            out_data;

    proximity_vector_fusion dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // arctangent table on a 2^32 turn
    localparam logic [31:0] ARCTAN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };
    localparam int REG_WIDTH [0:7] = '{16, 16, 24, 16, 16, 16, 24, 16};

    // predictor state
    longint              regs [0:7];
    longint              acc_x;
    longint              acc_y;
    int                  frame_items;
    pvf_pkg::out_item_t  pending_vectors [$];

    longint cycles;
    int     errors;
    int     items_sent;
    int     frames_checked;
    int     phases;
    bit     idle_on;
    bit     stall_on;
    int     stall_pct;
    int     burst_left;
    bit     hold_req;
    int     hold_left;

    task automatic report(string what, longint got, longint want);
        $display("error at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic longint sat24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    function automatic longint weight_calc(longint d, longint ofs, longint gain);
        longint r;
        longint w;
        if (d == 0)
            r = 24'hFFFFFF;
        else
        begin
            r = (longint'(1) << 24) / d;
            if (r > 24'hFFFFFF)
                r = 24'hFFFFFF;
        end
        w = ((r - ofs) * gain) >>> 13;
        if (w < 0)
            w = 0;
        if (w > 32768)
            w = 32768;
        return w;
    endfunction

    task automatic rotate_into_sums(longint w, logic signed [15:0] ang);
        longint z;
        longint x;
        longint y;
        longint nx;
        z = longint'(ang) * 65536;
        x = w * 39797;
        y = 0;
        if (z > 64'sh40000000)
        begin
            x = -x;
            z = z - 64'sh80000000;
        end
        else if (z < -64'sh40000000)
        begin
            x = -x;
            z = z + 64'sh80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ARCTAN[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ARCTAN[i]);
            end
            x = nx;
        end
        acc_x = sat24(acc_x + (x >>> 16));
        acc_y = sat24(acc_y + (y >>> 16));
    endtask

    function automatic pvf_pkg::out_item_t fused_vector(longint sx, longint sy);
        pvf_pkg::out_item_t o;
        longint      x;
        longint      y;
        longint      nx;
        longint      m;
        logic [31:0] z;
        logic [31:0] t;
        o = '0;
        if (sx == 0 && sy == 0)
            return o;
        x = sx * 256;
        y = sy * 256;
        z = 32'h0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end
            x = nx;
        end
        m = (x * 39797) >>> 24;
        if (m < 0)
            m = 0;
        if (m > 32768)
            m = 32768;
        t = z + 32'h8000;
        o.magnitude = m[15:0];
        o.direction = t[31:16];
        return o;
    endfunction

    task automatic predict_item(pvf_pkg::in_item_t it);
        longint w;
        longint d;
        longint g;
        w = 0;
        d = it.distance;
        if (frame_items < FRAME_LIMIT)
        begin
            frame_items++;
            if (it.command == 1'b0)
            begin
                if (d >= regs[pvf_pkg::REG_PROX_MIN] && d <= regs[pvf_pkg::REG_PROX_MAX])
                    w = weight_calc(d, regs[pvf_pkg::REG_PROX_OFS],
                                    regs[pvf_pkg::REG_PROX_GAIN]);
            end
            else if (it.blob_is_red && d <= regs[pvf_pkg::REG_NB_REACH])
            begin
                g = d - regs[pvf_pkg::REG_ROBOT_GAP];
                if (g <= 0)
                    g = 4;
                w = weight_calc(g, regs[pvf_pkg::REG_NB_OFS], regs[pvf_pkg::REG_NB_GAIN]);
            end
            if (w != 0)
                rotate_into_sums(w, it.angle);
        end
        if (it.last)
        begin
            pending_vectors = {pending_vectors, fused_vector(acc_x, acc_y)};
            acc_x = 0;
            acc_y = 0;
            frame_items = 0;
        end
    endtask

    // one input transaction, with burst and gap pacing
    task automatic send_item(pvf_pkg::in_item_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        predict_item(it);
        items_sent++;
        if (idle_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_fields(bit cmd, int d, int ang, bit red, bit lst);
        pvf_pkg::in_item_t it;
        it.command     = cmd;
        it.distance    = d[15:0];
        it.angle       = ang[15:0];
        it.blob_is_red = red;
        it.last        = lst;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [pvf_pkg::CFG_IDX_W-1:0] idx, longint value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[pvf_pkg::CFG_W-1:0];
        @(posedge clk);
        regs[idx] = value & ((longint'(1) << REG_WIDTH[idx]) - 1);
    endtask

    task automatic write_all(longint v0, longint v1, longint v2, longint v3,
                             longint v4, longint v5, longint v6, longint v7);
        write_reg(pvf_pkg::REG_PROX_MIN, v0);
        write_reg(pvf_pkg::REG_PROX_MAX, v1);
        write_reg(pvf_pkg::REG_PROX_OFS, v2);
        write_reg(pvf_pkg::REG_PROX_GAIN, v3);
        write_reg(pvf_pkg::REG_NB_REACH, v4);
        write_reg(pvf_pkg::REG_ROBOT_GAP, v5);
        write_reg(pvf_pkg::REG_NB_OFS, v6);
        write_reg(pvf_pkg::REG_NB_GAIN, v7);
        cfg_we <= 1'b0;
        phases++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("proximity_vector_fusion: mismatch");
            $finish;
        end
    end

    // receiver stall pattern, plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
            hold_left = 3000;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= stall_on && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        pvf_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_vectors.size() == 0)
                report("unexpected transaction, magnitude", out_data.magnitude, -1);
            else
            begin
                want = pending_vectors.pop_front();
                frames_checked++;
                if (out_data.magnitude !== want.magnitude)
                    report("magnitude", out_data.magnitude, want.magnitude);
                if (out_data.direction !== want.direction)
                    report("direction", $signed(out_data.direction), $signed(want.direction));
            end
        end
    end

    task automatic test_directed();
        // default registers: band 205..1638, reach 2253, gap 1126
        send_fields(0, 205, 0, 0, 0);
        send_fields(0, 1638, 16384, 0, 0);
        send_fields(0, 204, -16384, 0, 0);
        send_fields(0, 1639, 32767, 0, 1);
        send_fields(0, 300, -32768, 0, 1);
        send_fields(0, 300, 32767, 0, 1);
        send_fields(0, 300, 16385, 1, 1);
        send_fields(1, 2000, 1000, 1, 0);
        send_fields(1, 2253, -20000, 1, 0);
        send_fields(1, 500, 5000, 1, 1);
        send_fields(1, 1126, 0, 1, 1);
        send_fields(1, 1500, 0, 0, 0);
        send_fields(1, 2254, 0, 1, 0);
        send_fields(0, 65535, 0, 1, 1);
        send_fields(0, 0, 0, 0, 1);
        send_fields(1, 1130, -32768, 1, 0);
        send_fields(0, 400, 32767, 0, 1);
        wait_idle();
    endtask

    task automatic test_extremes();
        // full band, zero offsets, largest gains: weights of near items clamp at one
        write_all(0, 65535, 0, 65535, 65535, 0, 0, 65535);
        send_fields(0, 0, 0, 0, 1);
        send_fields(0, 65535, 12345, 0, 1);
        send_fields(1, 0, -32768, 1, 1);
        send_fields(1, 65535, 32767, 1, 1);
        for (int i = 0; i < 70; i++)
            send_fields(i[0], 10, -32768 + i * 7, 1, i == 69);
        wait_idle();
        // largest offsets, zero gains: every weight is zero
        write_all(65535, 0, 24'hFFFFFF, 0, 0, 65535, 24'hFFFFFF, 0);
        send_fields(0, 0, 100, 0, 0);
        send_fields(1, 0, 100, 1, 1);
        send_fields(0, 65535, 100, 1, 1);
        wait_idle();
    endtask

    task automatic random_config();
        longint lo;
        longint nb_lo;
        lo = $urandom_range(0, 3000);
        nb_lo = $urandom_range(0, 2000);
        if ($urandom_range(0, 4) == 0)
            write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 65535));
        else
            write_all(lo, lo + $urandom_range(0, 20000), $urandom_range(0, 40000),
                      $urandom_range(0, 65535), nb_lo + $urandom_range(0, 20000),
                      nb_lo, $urandom_range(0, 40000), $urandom_range(0, 65535));
    endtask

    task automatic random_frame(int len);
        int  d;
        int  pick;
        bit  cmd;
        for (int i = 0; i < len; i++)
        begin
            cmd  = $urandom_range(0, 1);
            pick = $urandom_range(0, 7);
            if (pick < 4)
                d = cmd ? $urandom_range(regs[pvf_pkg::REG_ROBOT_GAP],
                                         regs[pvf_pkg::REG_NB_REACH] + 10)
                        : $urandom_range(regs[pvf_pkg::REG_PROX_MIN],
                                         regs[pvf_pkg::REG_PROX_MAX] + 10);
            else if (pick < 6)
                d = $urandom_range(0, 65535);
            else
                d = $urandom_range(0, 16);
            send_fields(cmd, d, $urandom_range(0, 65535), $urandom_range(0, 3) != 0,
                        i == len - 1);
        end
    endtask

    task automatic test_random();
        int len;
        for (int p = 0; p < 10; p++)
        begin
            if (p == 0)
                write_all(205, 1638, 10240, 3745, 2253, 1126, 14894, 66);
            else
                random_config();
            idle_on  = (p % 3) != 2;
            stall_on = (p % 4) != 3;
            stall_pct = $urandom_range(10, 70);
            for (int n = 0; n < 165; n += len)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                  : $urandom_range(1, 12);
                random_frame(len);
            end
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int f = 0; f < 12; f++)
            random_frame(4);
        wait_idle();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        hold_req  <= 1'b0;
        cycles = 0;
        errors = 0;
        items_sent = 0;
        frames_checked = 0;
        phases = 0;
        hold_left = 0;
        burst_left = 0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        stall_pct = 30;
        regs = '{205, 1638, 10240, 3745, 2253, 1126, 14894, 66};
        acc_x = 0;
        acc_y = 0;
        frame_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extremes();
        test_random();
        test_backpressure();

        $display("sent %0d readings over %0d register settings", items_sent, phases);
        $display("checked %0d fused vectors, %0d errors", frames_checked, errors);
        if (errors == 0)
            $display("proximity_vector_fusion: match");
        else
            $display("proximity_vector_fusion: mismatch");
        $finish;
    end

endmodule
